### rtl/elg_pkg.sv
// shared types and constants of the elgamal sign and verify engine
`default_nettype none
package elg_pkg;

  localparam int WORD_BITS = 32;
  localparam int CNT_BITS  = $clog2(WORD_BITS);

  localparam logic CMD_SIGN   = 1'b0;
  localparam logic CMD_VERIFY = 1'b1;

  localparam logic [1:0] REG_MODULUS   = 2'd0;
  localparam logic [1:0] REG_GENERATOR = 2'd1;
  localparam logic [1:0] REG_SECRET    = 2'd2;
  localparam logic [1:0] REG_PUBLIC    = 2'd3;

  typedef enum logic [1:0] {
    UOP_MUL = 2'b01,
    UOP_DIV = 2'b10
  } uop_t;

  typedef struct packed {
    logic start;
    uop_t op;
  } unit_req_t;

  typedef struct packed {
    logic                 cmd;
    logic [WORD_BITS-1:0] message_hash;
    logic [WORD_BITS-1:0] nonce;
    logic [WORD_BITS-1:0] sig_first_in;
    logic [WORD_BITS-1:0] sig_second_in;
  } in_word_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] sig_first;
    logic [WORD_BITS-1:0] sig_second;
    logic                 sign_error;
    logic                 verified;
  } out_word_t;

endpackage
`default_nettype wire

### rtl/elg_mod_unit.sv
// shared bit-serial modular multiplier and restoring divider
`default_nettype none
module elg_mod_unit (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire elg_pkg::unit_req_t            req,
  input  wire logic [elg_pkg::WORD_BITS-1:0] op_a,
  input  wire logic [elg_pkg::WORD_BITS-1:0] op_b,
  input  wire logic [elg_pkg::WORD_BITS-1:0] op_m,
  output logic                               done,
  output logic [elg_pkg::WORD_BITS-1:0]      res,
  output logic [elg_pkg::WORD_BITS-1:0]      quot
);
  import elg_pkg::*;

  logic                 busy;
  logic [CNT_BITS-1:0]  cnt;
  uop_t                 op;
  logic [WORD_BITS-1:0] a;
  logic [WORD_BITS-1:0] b;
  logic [WORD_BITS-1:0] m;
  logic [WORD_BITS-1:0] r;
  logic [WORD_BITS-1:0] q;

  logic [WORD_BITS:0]   dbl;
  logic [WORD_BITS:0]   dbl_r;
  logic [WORD_BITS:0]   sum;
  logic [WORD_BITS:0]   sum_r;
  logic [WORD_BITS:0]   tdiv;
  logic                 ge;
  logic [WORD_BITS-1:0] r_next;

  always_comb begin
    dbl   = {r, 1'b0};
    dbl_r = (dbl >= {1'b0, m}) ? dbl - {1'b0, m} : dbl;
    sum   = {1'b0, dbl_r[WORD_BITS-1:0]} + {1'b0, a};
    sum_r = (sum >= {1'b0, m}) ? sum - {1'b0, m} : sum;
    tdiv  = {r, b[WORD_BITS-1]};
    ge    = (tdiv >= {1'b0, m});
    if (op == UOP_DIV) begin
      r_next = ge ? WORD_BITS'(tdiv - {1'b0, m}) : tdiv[WORD_BITS-1:0];
    end else begin
      r_next = b[WORD_BITS-1] ? sum_r[WORD_BITS-1:0] : dbl_r[WORD_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CNT_BITS'(WORD_BITS - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      op <= req.op;
      a  <= op_a;
      b  <= op_b;
      m  <= op_m;
      r  <= '0;
      q  <= '0;
    end else if (busy) begin
      r <= r_next;
      q <= {q[WORD_BITS-2:0], ge};
      b <= {b[WORD_BITS-2:0], 1'b0};
    end
  end

  assign res  = r;
  assign quot = q;

endmodule
`default_nettype wire

### rtl/elgamal32_sign_verify_unit.sv
// top level of the elgamal sign and verify engine: registers, sequencer, shared unit
// each modular multiply or reduction runs bit-serially on the shared unit
// sign: 32 to 64 multiplies for g^k, 7 more steps, 2 per euclid round
// verify: three exponentiations of up to 64 multiplies each
// one word at a time; the result waits in an output register until taken
// synchronous reset sets p=2, g=1, x=0, h=1 and returns the sequencer to idle
`default_nettype none
module elgamal32_sign_verify_unit (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [3:0]                    paddr,
  input  wire logic [31:0]                   pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready,
  input  wire logic                          req_valid,
  output logic                               req_stall,
  input  wire elg_pkg::in_word_t             req,
  output logic                               rsp_valid,
  input  wire logic                          rsp_stall,
  output elg_pkg::out_word_t                 rsp
);
  import elg_pkg::*;

  typedef enum logic [19:0] {
    ST_IDLE    = 20'h00001,
    ST_OUT     = 20'h00002,
    ST_POW_SQ  = 20'h00004,
    ST_POW_MUL = 20'h00008,
    ST_SG_GRED = 20'h00010,
    ST_SG_KRED = 20'h00020,
    ST_SG_EUC  = 20'h00040,
    ST_SG_EDIV = 20'h00080,
    ST_SG_EMUL = 20'h00100,
    ST_SG_XRED = 20'h00200,
    ST_SG_ARED = 20'h00400,
    ST_SG_MRED = 20'h00800,
    ST_SG_XA   = 20'h01000,
    ST_SG_B    = 20'h02000,
    ST_VF_HRED = 20'h04000,
    ST_VF_ARED = 20'h08000,
    ST_VF_P2   = 20'h10000,
    ST_VF_LHS  = 20'h20000,
    ST_VF_GRED = 20'h40000,
    ST_VF_CMP  = 20'h80000
  } state_t;

  state_t               state;
  state_t               ret;
  logic                 pend;

  logic [WORD_BITS-1:0] p;
  logic [WORD_BITS-1:0] g;
  logic [WORD_BITS-1:0] x;
  logic [WORD_BITS-1:0] h;

  in_word_t             item;
  out_word_t            result;

  logic [WORD_BITS-1:0] base;
  logic [WORD_BITS-1:0] expo;
  logic [WORD_BITS-1:0] acc;
  logic [CNT_BITS-1:0]  pcnt;
  logic [WORD_BITS-1:0] r0;
  logic [WORD_BITS-1:0] r1;
  logic [WORD_BITS-1:0] s0;
  logic [WORD_BITS-1:0] s1;
  logic [WORD_BITS-1:0] qv;
  logic [WORD_BITS-1:0] tmp1;
  logic [WORD_BITS-1:0] tmp2;
  logic [WORD_BITS-1:0] tmp3;
  logic [WORD_BITS-1:0] inv;
  logic [WORD_BITS-1:0] aval;

  logic [WORD_BITS-1:0] n;
  logic                 p_small;
  logic                 uses_unit;
  unit_req_t            ureq;
  logic [WORD_BITS-1:0] ua;
  logic [WORD_BITS-1:0] ub;
  logic [WORD_BITS-1:0] um;
  logic                 udone;
  logic [WORD_BITS-1:0] ures;
  logic [WORD_BITS-1:0] uquot;
  logic [WORD_BITS-1:0] sub_res;
  logic [WORD_BITS-1:0] sub_x;
  logic [WORD_BITS-1:0] sub_y;
  logic                 cfg_wr;
  logic                 pow_last;

  assign n       = p - 1'b1;
  assign p_small = (p[WORD_BITS-1:1] == '0);
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign pow_last = (pcnt == '0);

  always_comb begin
    unique case (paddr[3:2])
      REG_MODULUS:   prdata = p;
      REG_GENERATOR: prdata = g;
      REG_SECRET:    prdata = x;
      REG_PUBLIC:    prdata = h;
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p <= WORD_BITS'(2);
      g <= WORD_BITS'(1);
      x <= '0;
      h <= WORD_BITS'(1);
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_MODULUS:   p <= pwdata;
        REG_GENERATOR: g <= pwdata;
        REG_SECRET:    x <= pwdata;
        REG_PUBLIC:    h <= pwdata;
        default: ;
      endcase
    end
  end

  // operand select for the shared unit
  always_comb begin
    uses_unit = 1'b1;
    ureq.op   = UOP_DIV;
    ua        = '0;
    ub        = '0;
    um        = p;
    unique case (state)
      ST_POW_SQ:  begin ureq.op = UOP_MUL; ua = acc; ub = acc; end
      ST_POW_MUL: begin ureq.op = UOP_MUL; ua = base; ub = acc; end
      ST_SG_GRED: ub = g;
      ST_SG_KRED: begin ub = item.nonce; um = n; end
      ST_SG_EDIV: begin ub = r0; um = r1; end
      ST_SG_EMUL: begin ureq.op = UOP_MUL; ua = s1; ub = qv; um = n; end
      ST_SG_XRED: begin ub = x; um = n; end
      ST_SG_ARED: begin ub = aval; um = n; end
      ST_SG_MRED: begin ub = item.message_hash; um = n; end
      ST_SG_XA:   begin ureq.op = UOP_MUL; ua = tmp2; ub = tmp1; um = n; end
      ST_SG_B:    begin ureq.op = UOP_MUL; ua = inv; ub = tmp3; um = n; end
      ST_VF_HRED: ub = h;
      ST_VF_ARED: ub = item.sig_first_in;
      ST_VF_LHS:  begin ureq.op = UOP_MUL; ua = acc; ub = tmp2; end
      ST_VF_GRED: ub = g;
      default:    uses_unit = 1'b0;
    endcase
    ureq.start = uses_unit & ~pend;
  end

  // (sub_x - sub_y) mod n for reduced operands
  always_comb begin
    if (state == ST_SG_EMUL) begin
      sub_x = s0;
    end else begin
      sub_x = tmp3;
    end
    sub_y   = ures;
    sub_res = (sub_x >= sub_y) ? sub_x - sub_y : sub_x - sub_y + n;
  end

  elg_mod_unit u_mod (
    .clk  (clk),
    .rst  (rst),
    .req  (ureq),
    .op_a (ua),
    .op_b (ub),
    .op_m (um),
    .done (udone),
    .res  (ures),
    .quot (uquot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      ret   <= ST_IDLE;
      pend  <= 1'b0;
    end else begin
      if (ureq.start) begin
        pend <= 1'b1;
      end else if (udone) begin
        pend <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (req_valid) begin
            item <= req;
            if (p_small) begin
              result <= '{sig_first: '0, sig_second: '0,
                          sign_error: (req.cmd == CMD_SIGN), verified: 1'b0};
              state  <= ST_OUT;
            end else if (req.cmd == CMD_SIGN) begin
              result <= '0;
              state  <= ST_SG_GRED;
            end else begin
              result <= '0;
              state  <= ST_VF_HRED;
            end
          end
        end
        ST_OUT: begin
          if (!rsp_stall) begin
            state <= ST_IDLE;
          end
        end
        ST_POW_SQ: begin
          if (pend && udone) begin
            acc <= ures;
            if (expo[pcnt]) begin
              state <= ST_POW_MUL;
            end else if (pow_last) begin
              state <= ret;
            end else begin
              pcnt  <= pcnt - 1'b1;
              state <= ST_POW_SQ;
            end
          end
        end
        ST_POW_MUL: begin
          if (pend && udone) begin
            acc <= ures;
            if (pow_last) begin
              state <= ret;
            end else begin
              pcnt  <= pcnt - 1'b1;
              state <= ST_POW_SQ;
            end
          end
        end
        ST_SG_GRED: begin
          if (pend && udone) begin
            base  <= ures;
            expo  <= item.nonce;
            acc   <= WORD_BITS'(1);
            pcnt  <= CNT_BITS'(WORD_BITS - 1);
            ret   <= ST_SG_KRED;
            state <= ST_POW_SQ;
          end
        end
        ST_SG_KRED: begin
          if (pend && udone) begin
            aval  <= acc;
            r0    <= n;
            r1    <= ures;
            s0    <= '0;
            s1    <= (n == WORD_BITS'(1)) ? '0 : WORD_BITS'(1);
            state <= ST_SG_EUC;
          end
        end
        ST_SG_EUC: begin
          if (r1 == '0) begin
            inv   <= '0;
            state <= ST_SG_XRED;
          end else if (r1 == WORD_BITS'(1)) begin
            inv   <= s1;
            state <= ST_SG_XRED;
          end else begin
            state <= ST_SG_EDIV;
          end
        end
        ST_SG_EDIV: begin
          if (pend && udone) begin
            qv    <= uquot;
            tmp1  <= ures;
            state <= ST_SG_EMUL;
          end
        end
        ST_SG_EMUL: begin
          if (pend && udone) begin
            r0    <= r1;
            r1    <= tmp1;
            s0    <= s1;
            s1    <= sub_res;
            state <= ST_SG_EUC;
          end
        end
        ST_SG_XRED: begin
          if (pend && udone) begin
            tmp1  <= ures;
            state <= ST_SG_ARED;
          end
        end
        ST_SG_ARED: begin
          if (pend && udone) begin
            tmp2  <= ures;
            state <= ST_SG_MRED;
          end
        end
        ST_SG_MRED: begin
          if (pend && udone) begin
            tmp3  <= ures;
            state <= ST_SG_XA;
          end
        end
        ST_SG_XA: begin
          if (pend && udone) begin
            tmp3  <= sub_res;
            state <= ST_SG_B;
          end
        end
        ST_SG_B: begin
          if (pend && udone) begin
            result.sig_first  <= aval;
            result.sig_second <= ures;
            result.sign_error <= (ures == '0);
            state             <= ST_OUT;
          end
        end
        ST_VF_HRED: begin
          if (pend && udone) begin
            base  <= ures;
            state <= ST_VF_ARED;
          end
        end
        ST_VF_ARED: begin
          if (pend && udone) begin
            tmp1  <= ures;
            expo  <= item.sig_first_in;
            acc   <= WORD_BITS'(1);
            pcnt  <= CNT_BITS'(WORD_BITS - 1);
            ret   <= ST_VF_P2;
            state <= ST_POW_SQ;
          end
        end
        ST_VF_P2: begin
          tmp2  <= acc;
          base  <= tmp1;
          expo  <= item.sig_second_in;
          acc   <= WORD_BITS'(1);
          pcnt  <= CNT_BITS'(WORD_BITS - 1);
          ret   <= ST_VF_LHS;
          state <= ST_POW_SQ;
        end
        ST_VF_LHS: begin
          if (pend && udone) begin
            tmp2  <= ures;
            state <= ST_VF_GRED;
          end
        end
        ST_VF_GRED: begin
          if (pend && udone) begin
            base  <= ures;
            expo  <= item.message_hash;
            acc   <= WORD_BITS'(1);
            pcnt  <= CNT_BITS'(WORD_BITS - 1);
            ret   <= ST_VF_CMP;
            state <= ST_POW_SQ;
          end
        end
        ST_VF_CMP: begin
          result.verified <= (acc == tmp2);
          state           <= ST_OUT;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign req_stall = (state != ST_IDLE);
  assign rsp_valid = (state == ST_OUT);
  assign rsp       = result;

endmodule
`default_nettype wire

### dv/tb.sv
// self-checking testbench of the elgamal sign and verify engine
module tb;
  import elg_pkg::*;

  typedef struct {
    logic [31:0] addr;
    logic [31:0] data;
    logic        is_cfg;
    in_word_t    w;
  } pend_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic req_valid = 1'b0;
  logic req_stall;
  in_word_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  out_word_t rsp;

  elgamal32_sign_verify_unit dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  logic [31:0] mod_p = 32'd2, gen_g = 32'd1, key_x = 32'd0, pub_h = 32'd1;
  pend_t pending[$];
  out_word_t sig_results[$];
  int errors = 0;
  int cyc = 0;
  bit quiet = 1'b0;
  bit hold = 1'b0;
  bit done_stim = 1'b0;

  function automatic logic [31:0] mulmod(logic [31:0] a, logic [31:0] b, logic [31:0] m);
    logic [63:0] t;
    t = 64'(a) * 64'(b);
    return 32'(t % 64'(m));
  endfunction

  function automatic logic [31:0] powmod(logic [31:0] b, logic [31:0] e, logic [31:0] m);
    logic [31:0] r;
    r = 32'd1 % m;
    b = b % m;
    for (int i = 31; i >= 0; i--) begin
      r = mulmod(r, r, m);
      if (e[i]) r = mulmod(r, b, m);
    end
    return r;
  endfunction

  function automatic logic [31:0] invmod(logic [31:0] k, logic [31:0] n);
    logic [31:0] r0, r1, r2, s0, s1, s2, q;
    r0 = n; r1 = k % n; s0 = 0; s1 = 32'd1 % n;
    while (r1 != 0) begin
      if (r1 == 1) return s1;
      q = r0 / r1;
      r2 = r0 - q * r1;
      s2 = mulmod(q % n, s1, n);
      s2 = (s0 >= s2) ? s0 - s2 : s0 + (n - s2);
      r0 = r1; r1 = r2; s0 = s1; s1 = s2;
    end
    return 0;
  endfunction

  function automatic out_word_t sign_verify(in_word_t w);
    out_word_t o;
    logic [31:0] n, a, t, u, l, r;
    o = '0;
    if (mod_p < 2) begin
      if (w.cmd == CMD_SIGN) o.sign_error = 1'b1;
      return o;
    end
    if (w.cmd == CMD_SIGN) begin
      n = mod_p - 1;
      a = powmod(gen_g, w.nonce, mod_p);
      u = mulmod(key_x % n, a % n, n);
      t = w.message_hash % n;
      t = (t >= u) ? t - u : t + (n - u);
      o.sig_first = a;
      o.sig_second = mulmod(invmod(w.nonce, n), t, n);
      o.sign_error = (o.sig_second == 0);
    end else begin
      l = mulmod(powmod(pub_h, w.sig_first_in, mod_p),
                 powmod(w.sig_first_in, w.sig_second_in, mod_p), mod_p);
      r = powmod(gen_g, w.message_hash, mod_p);
      o.verified = (l == r);
    end
    return o;
  endfunction

  task automatic add_cfg(logic [1:0] idx, logic [31:0] v);
    pend_t p;
    p.is_cfg = 1'b1; p.addr = 32'(idx) * 4; p.data = v; p.w = '0;
    pending.push_back(p);
  endtask

  task automatic add_item(logic c, logic [31:0] m, logic [31:0] k,
                          logic [31:0] a, logic [31:0] b);
    pend_t p;
    p.is_cfg = 1'b0; p.addr = 0; p.data = 0;
    p.w.cmd = c; p.w.message_hash = m; p.w.nonce = k;
    p.w.sig_first_in = a; p.w.sig_second_in = b;
    pending.push_back(p);
  endtask

  // driver
  typedef enum logic [1:0] {DRV_IDLE, DRV_SETUP, DRV_ACCESS, DRV_WORD} drv_t;
  drv_t drv = DRV_IDLE;
  int wait_cyc = 0;
  pend_t cur;

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (!rst) begin
      case (drv)
        DRV_IDLE: begin
          if (pending.size() > 0 && !hold) begin
            if (pending[0].is_cfg) begin
              if (sig_results.size() == 0 && !rsp_valid) begin
                if (wait_cyc < 40) wait_cyc <= wait_cyc + 1;
                else begin
                  wait_cyc <= 0;
                  cur = pending.pop_front();
                  psel <= 1'b1; pwrite <= 1'b1;
                  paddr <= cur.addr[3:0]; pwdata <= cur.data;
                  drv <= DRV_SETUP;
                end
              end
            end else if (quiet || $urandom_range(99) >= 27) begin
              cur = pending.pop_front();
              req <= cur.w;
              req_valid <= 1'b1;
              drv <= DRV_WORD;
            end
          end
        end
        DRV_SETUP: begin
          penable <= 1'b1;
          drv <= DRV_ACCESS;
        end
        DRV_ACCESS: begin
          if (pready) begin
            case (cur.addr[3:2])
              REG_MODULUS: mod_p = cur.data;
              REG_GENERATOR: gen_g = cur.data;
              REG_SECRET: key_x = cur.data;
              default: pub_h = cur.data;
            endcase
            psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
            drv <= DRV_IDLE;
          end
        end
        DRV_WORD: begin
          if (!req_stall) begin
            sig_results.push_back(sign_verify(req));
            if (pending.size() > 0 && !pending[0].is_cfg && !hold &&
                (quiet || $urandom_range(99) >= 27)) begin
              cur = pending.pop_front();
              req <= cur.w;
            end else begin
              req_valid <= 1'b0;
              drv <= DRV_IDLE;
            end
          end
        end
      endcase
    end
  end

  // monitor
  out_word_t want;
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_valid && !rsp_stall) begin
        if (sig_results.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected word %h", rsp);
        end else begin
          want = sig_results.pop_front();
          if (rsp.sig_first !== want.sig_first || rsp.sig_second !== want.sig_second ||
              rsp.sign_error !== want.sign_error || rsp.verified !== want.verified) begin
            errors++;
            if (errors <= 10) $display("mismatch exp %h got %h", want, rsp);
          end
        end
      end
      rsp_stall <= quiet ? 1'b0 : ($urandom_range(99) < 27);
    end
  end

  function automatic logic [31:0] rnd_prime(bit big);
    logic [31:0] c;
    bit ok;
    do begin
      c = big ? ($urandom | 32'h8000_0001) : ($urandom_range(65000, 3) | 1);
      ok = 1'b1;
      for (logic [31:0] d = 3; d * d <= c && d < 65536; d += 2)
        if (c % d == 0) begin ok = 1'b0; break; end
    end while (!ok);
    return c;
  endfunction

  task automatic random_keys(bit big);
    logic [31:0] p, g, x;
    p = rnd_prime(big);
    g = $urandom_range(2, 5000) % p;
    x = $urandom;
    add_cfg(REG_MODULUS, p);
    add_cfg(REG_GENERATOR, g);
    add_cfg(REG_SECRET, x);
    add_cfg(REG_PUBLIC, ($urandom_range(9) == 0) ? $urandom : powmod(g, x, p));
  endtask

  task automatic wait_drain();
    while (pending.size() > 0 || sig_results.size() > 0 || req_valid) @(negedge clk);
  endtask

  initial begin
    logic [31:0] m, k, a, b;
    in_word_t w;
    out_word_t o;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    // reset settings and extremes
    add_item(CMD_SIGN, 32'hffff_ffff, 32'hffff_ffff, 0, 0);
    add_item(CMD_VERIFY, 0, 0, 32'hffff_ffff, 32'hffff_ffff);
    add_cfg(REG_MODULUS, 0);
    add_item(CMD_SIGN, 5, 7, 0, 0);
    add_item(CMD_VERIFY, 5, 0, 3, 4);
    add_cfg(REG_MODULUS, 1);
    add_item(CMD_SIGN, 5, 7, 0, 0);
    add_item(CMD_VERIFY, 5, 0, 3, 4);
    add_cfg(REG_MODULUS, 32'hffff_fffb);
    add_cfg(REG_GENERATOR, 32'hffff_ffff);
    add_cfg(REG_SECRET, 32'hffff_ffff);
    add_cfg(REG_PUBLIC, 32'hffff_ffff);
    add_item(CMD_SIGN, 32'hffff_ffff, 32'hffff_ffff, 0, 0);
    add_item(CMD_SIGN, 0, 0, 0, 0);
    add_item(CMD_SIGN, 7, 2, 0, 0);
    add_item(CMD_SIGN, 7, 1, 32'hffff_ffff, 32'hffff_ffff);
    add_item(CMD_VERIFY, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    add_item(CMD_VERIFY, 0, 0, 0, 0);
    add_cfg(REG_MODULUS, 23);
    add_cfg(REG_GENERATOR, 5);
    add_cfg(REG_SECRET, 6);
    add_cfg(REG_PUBLIC, 8);
    add_item(CMD_SIGN, 10, 3, 0, 0);
    add_item(CMD_VERIFY, 10, 0, 10, 20);
    add_item(CMD_VERIFY, 10, 0, 10, 18);
    wait_drain();
    for (int ph = 0; ph < 8; ph++) begin
      random_keys(ph % 3 == 0);
      for (int i = 0; i < 24; i++) begin
        m = $urandom; k = $urandom;
        if ($urandom_range(3) == 0) k = k & 32'hff;
        if ($urandom_range(9) < 6) begin
          add_item(CMD_SIGN, m, k, $urandom, $urandom);
        end else begin
          a = $urandom; b = $urandom;
          add_item(CMD_VERIFY, m, $urandom, a, b);
        end
      end
      if (ph == 3) quiet = 1'b1;
      if (ph == 5) quiet = 1'b0;
      wait_drain();
      if (ph == 1) begin
        hold = 1'b1;
        repeat (50) @(posedge clk);
        hold = 1'b0;
      end
    end
    // sign then verify a fresh pair against the same keys
    for (int i = 0; i < 10; i++) begin
      w = '0;
      w.cmd = CMD_SIGN;
      w.message_hash = $urandom;
      w.nonce = $urandom | 1;
      o = sign_verify(w);
      add_item(CMD_SIGN, w.message_hash, w.nonce, 0, 0);
      add_item(CMD_VERIFY, w.message_hash, 0, o.sig_first, o.sig_second);
    end
    wait_drain();
    done_stim = 1'b1;
    repeat (200) @(posedge clk);
    if (errors == 0 && sig_results.size() == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  initial begin
    #200000000;
    $display("TB_ERROR");
    $finish;
  end
endmodule

### filelist.f
rtl/elg_pkg.sv
rtl/elg_mod_unit.sv
rtl/elgamal32_sign_verify_unit.sv
dv/tb.sv
